@@ hdl/stkvt_pkg.sv @@
// shared types and codes for the sparse triple-key value table
`default_nettype none

package stkvt_pkg;

    localparam int unsigned IX_W  = 11;
    localparam int unsigned KEY_W = 3 * IX_W;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned ACT_W = 3;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUB    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [VAL_W-1:0] VAL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_NEG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VREAD,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

@@ hdl/sparse_triple_key_value_table_core.sv @@
// sparse triple-key value table: key search, value read-modify-write and output register
// each item runs the key memory scan, one key read per cycle, until a hit or the last stored entry,
// then one value memory read, held until the output register can take the result, and one update;
// clear, and any item on an empty table, skip the scan
// one item in flight; the next input transfer is taken once the result sits in the output register
// synchronous active-low reset empties the table, clears the largest index, the default value
// and the output valid; the memories keep their contents and need no clearing pass
`default_nettype none

module sparse_triple_key_value_table_core #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned INDEX_MAX = 1023
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration: default value, q16.16
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [stkvt_pkg::VAL_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata from bit 0: first_index(11), second_index(11), third_index(11),
    // operand_value(32), zero fill
    input  wire logic [71:0]                       s_axis_tdata,
    // tuser from bit 0: action(3)
    input  wire logic [stkvt_pkg::ACT_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata from bit 0: found(1), value_out(32), table_full(1),
    // largest_index($clog2(INDEX_MAX+1)), entry_count($clog2(CAPACITY+1)), zero fill
    output logic [((34 + $clog2(INDEX_MAX+1) + $clog2(CAPACITY+1) + 7) / 8) * 8 - 1:0]
                                                   m_axis_tdata
);

    import stkvt_pkg::*;

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned IDX_W  = $clog2(INDEX_MAX + 1);
    localparam int unsigned RES_W  = 2 + VAL_W + IDX_W + CNT_W;
    localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8;

    // storage
    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_action;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_operand;
    logic [VAL_W-1:0]   r_default;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_max;
    logic [CNT_W-1:0]   r_iss;
    logic               r_cmp_valid;
    logic [CNT_W-1:0]   r_cmp_idx;
    logic               r_found;
    logic [ADDR_W-1:0]  r_hit;
    logic [KEY_W-1:0]   r_key_q;
    logic [VAL_W-1:0]   r_val_q;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               in_xfer;
    logic               issue;
    logic               val_rd;
    logic               cmp_hit;
    logic               cmp_last;
    logic               out_free;

    logic               is_upd;
    logic [VAL_W-1:0]   base;
    logic [VAL_W:0]     sum;
    logic [VAL_W:0]     diff;
    logic [VAL_W-1:0]   nv;
    logic               wr_key_en;
    logic               wr_val_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               res_found;
    logic [VAL_W-1:0]   res_value;
    logic               res_full;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   n_max;

    // negative indices never count; larger ones clamp to the index ceiling
    function automatic logic [IDX_W-1:0] note_index(input logic [IDX_W-1:0] cur,
                                                    input logic [IX_W-1:0] ix);
        logic [16:0]      ext;
        logic [IDX_W-1:0] u;
        ext = 17'(ix[IX_W-2:0]);
        if (ext > 17'(INDEX_MAX)) begin
            u = IDX_W'(INDEX_MAX);
        end else begin
            u = IDX_W'(ext);
        end
        if (!ix[IX_W-1] && (u > cur)) begin
            return u;
        end
        return cur;
    endfunction

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign cmp_hit  = r_cmp_valid && (r_key_q == r_key);
    assign cmp_last = r_cmp_valid && (r_cmp_idx == (r_count - 1'b1));
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if ((r_count == '0) || (s_axis_tuser == ACT_CLEAR)) begin
                        n_state = ST_VREAD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmp_hit || cmp_last) begin
                    n_state = ST_VREAD;
                end
            end
            ST_VREAD: begin
                // the update may only run once the output register can take the result
                if (out_free) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        val_rd        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                issue = (r_iss < r_count);
            end
            ST_VREAD: begin
                val_rd = 1'b1;
            end
            ST_EXEC: begin
            end
            default: begin
            end
        endcase
    end

    // update datapath
    always_comb begin
        is_upd = (r_action == ACT_WRITE) || (r_action == ACT_ADD) || (r_action == ACT_SUB);
        base   = r_found ? r_val_q : r_default;
        sum    = {base[VAL_W-1], base} + {r_operand[VAL_W-1], r_operand};
        diff   = {base[VAL_W-1], base} - {r_operand[VAL_W-1], r_operand};
        priority if (r_action == ACT_WRITE) begin
            nv = r_operand;
        end else if (r_action == ACT_ADD) begin
            if (sum[VAL_W] != sum[VAL_W-1]) begin
                nv = sum[VAL_W] ? VAL_NEG_MAX : VAL_POS_MAX;
            end else begin
                nv = sum[VAL_W-1:0];
            end
        end else begin
            if (diff[VAL_W] != diff[VAL_W-1]) begin
                nv = diff[VAL_W] ? VAL_NEG_MAX : VAL_POS_MAX;
            end else begin
                nv = diff[VAL_W-1:0];
            end
        end

        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = r_hit;
        res_found = r_found;
        res_value = r_found ? r_val_q : r_default;
        res_full  = 1'b0;
        n_count   = r_count;
        n_max     = r_max;
        priority if (r_action == ACT_CLEAR) begin
            n_count   = '0;
            res_found = 1'b0;
            res_value = r_default;
        end else if (is_upd) begin
            priority if (r_found) begin
                wr_val_en = 1'b1;
                res_value = nv;
            end else if (r_count < CNT_W'(CAPACITY)) begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                wr_addr   = r_count[ADDR_W-1:0];
                n_count   = r_count + 1'b1;
                n_max     = note_index(note_index(note_index(r_max, r_key[IX_W-1:0]),
                                                  r_key[2*IX_W-1:IX_W]),
                                       r_key[3*IX_W-1:2*IX_W]);
                res_value = nv;
            end else begin
                res_full  = 1'b1;
                res_value = r_default;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_max       <= '0;
            r_default   <= '0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_iss       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_default <= i_cfg_data;
            end
            if (in_xfer) begin
                r_cmp_valid <= 1'b0;
                r_found     <= 1'b0;
                r_iss       <= '0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_iss <= r_iss + 1'b1;
                end
                if (cmp_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (r_state == ST_EXEC) begin
                r_count     <= n_count;
                r_max       <= n_max;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action  <= s_axis_tuser;
            r_key     <= s_axis_tdata[KEY_W-1:0];
            r_operand <= s_axis_tdata[KEY_W +: VAL_W];
        end
        if (issue) begin
            r_cmp_idx <= r_iss;
        end
        if ((r_state == ST_SCAN) && cmp_hit) begin
            r_hit <= r_cmp_idx[ADDR_W-1:0];
        end
        if (r_state == ST_EXEC) begin
            r_out_data <= OUT_W'({n_count, n_max, res_full, res_value, res_found});
        end
    end

    // key memory; a write lands in the update cycle, well before the next item reads
    always_ff @(posedge i_clk) begin
        if (wr_key_en && (r_state == ST_EXEC)) begin
            key_mem[wr_addr] <= r_key;
        end
        if (issue) begin
            r_key_q <= key_mem[r_iss[ADDR_W-1:0]];
        end
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (wr_val_en && (r_state == ST_EXEC)) begin
            val_mem[wr_addr] <= nv;
        end
        if (val_rd) begin
            r_val_q <= val_mem[r_hit];
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ hdl/stkvt_checker.sv @@
// port-level checks for the sparse triple-key value table, bound to the top level
`default_nettype none

module stkvt_checker #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned INDEX_MAX = 1023
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [stkvt_pkg::ACT_W-1:0]       s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [((34 + $clog2(INDEX_MAX+1) + $clog2(CAPACITY+1) + 7) / 8) * 8 - 1:0]
                                                  m_axis_tdata
);

    import stkvt_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(INDEX_MAX + 1);
    localparam int unsigned FULL_B = 1 + VAL_W;
    localparam int unsigned CNT_LO = 2 + VAL_W + IDX_W;

    logic [CNT_W-1:0] out_count;
    assign out_count = m_axis_tdata[CNT_LO +: CNT_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // a cleared table reports no entries and no hit; with no older result
    // left waiting, the next result shown is the one for the clear
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CLEAR)
        && (!m_axis_tvalid || m_axis_tready)
        |=> m_axis_tvalid[->1] ##0 ((out_count == '0) && !m_axis_tdata[0]))
        else $error("clear did not empty the table");

    // a dropped append only happens on a full table and a missing key
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[FULL_B]
        |-> !m_axis_tdata[0] && (out_count == CNT_W'(CAPACITY)))
        else $error("table_full without a full table");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sparse_triple_key_value_table_core stkvt_checker #(
    .CAPACITY  (CAPACITY),
    .INDEX_MAX (INDEX_MAX)
) u_stkvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
